FILE: design/packed_iq_sample_unpacker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packed IQ sample unpacker
// Clocked assertion wrappers. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef PACKED_IQ_SAMPLE_UNPACKER_ASSERT_SVH
`define PACKED_IQ_SAMPLE_UNPACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked on every rising edge, ignored while reset is high
`define PIQU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("piqu assertion failed");
// checked on every rising edge, reset included
`define PIQU_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("piqu assertion failed");
`else
`define PIQU_ASSERT(label, clk, rst, prop)
`define PIQU_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: design/piqu_pkg.sv
// ----------------------------------------------------------------------------
// piqu_pkg
// Shared depth codes, level constants and the pair job type.
// ----------------------------------------------------------------------------
`default_nettype none

package piqu_pkg;

  // sample depth register codes
  localparam logic [1:0] DEPTH_2  = 2'd0;
  localparam logic [1:0] DEPTH_4  = 2'd1;
  localparam logic [1:0] DEPTH_8  = 2'd2;
  localparam logic [1:0] DEPTH_16 = 2'd3;

  // outer 4-bit level 3.335875 as a ratio
  localparam longint LEVEL_HI_NUM = 3335875;
  localparam longint LEVEL_HI_DEN = 1000000;

  // one complete byte pair, ready for unpacking
  typedef struct packed {
    logic [7:0] odd_byte;
    logic [7:0] even_byte;
    logic [1:0] depth;
  } job_t;

endpackage

`default_nettype wire

FILE: design/piqu_pair.sv
// ----------------------------------------------------------------------------
// piqu_pair
// Input register: pairs even/odd bytes and holds one pair job.
// ----------------------------------------------------------------------------
`default_nettype none

module piqu_pair (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          byte_valid,
  output logic               byte_stall,
  input  wire logic [7:0]    byte_value,
  input  wire logic          end_of_block,
  input  wire logic          sample_depth_we,
  input  wire logic [1:0]    sample_depth,
  output logic               job_valid,
  output piqu_pkg::job_t     job,
  input  wire logic          job_take
);

  logic       pair_phase;
  logic [7:0] held_even_byte;
  logic [1:0] depth_setting;
  logic       accept;

  assign byte_stall = job_valid && !job_take;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_phase     <= 1'b0;
      held_even_byte <= 8'd0;
      depth_setting  <= piqu_pkg::DEPTH_4;
      job_valid      <= 1'b0;
    end else begin
      if (sample_depth_we) begin
        depth_setting <= sample_depth;
      end
      if (job_take) begin
        job_valid <= 1'b0;
      end
      if (accept) begin
        if (!pair_phase) begin
          // lone even byte at end of block is dropped
          if (!end_of_block) begin
            held_even_byte <= byte_value;
            pair_phase     <= 1'b1;
          end
        end else begin
          pair_phase <= 1'b0;
          job_valid  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pair_phase) begin
      job.odd_byte  <= byte_value;
      job.even_byte <= held_even_byte;
      job.depth     <= depth_setting;
    end
  end

endmodule

`default_nettype wire

FILE: design/piqu_slicer.sv
// ----------------------------------------------------------------------------
// piqu_slicer
// Walks one pair job a sample per cycle, unless the output stalls, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packed_iq_sample_unpacker_assert.svh"

module piqu_slicer #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               job_valid,
  input  wire piqu_pkg::job_t     job,
  output logic                    job_take,
  output logic                    sample_valid,
  input  wire logic               sample_stall,
  output logic signed [15:0]      sample_real,
  output logic signed [15:0]      sample_imag,
  output logic                    last_of_run
);

  // wide enough for a signed byte scaled up, and for the 16-bit limits
  localparam int PW = (8 + FRACTION_BITS > 16) ? 8 + FRACTION_BITS : 17;
  localparam logic signed [15:0] UNIT = 16'(longint'(1) << FRACTION_BITS);
  localparam logic signed [15:0] LEVEL_HI = 16'(
    (piqu_pkg::LEVEL_HI_NUM * (longint'(1) << FRACTION_BITS) +
     piqu_pkg::LEVEL_HI_DEN / 2) / piqu_pkg::LEVEL_HI_DEN);
  localparam logic signed [PW-1:0] SAT_MAX = PW'(32767);
  localparam logic signed [PW-1:0] SAT_MIN = PW'(-32768);

  function automatic logic signed [15:0] level4(input logic [1:0] c);
    logic signed [15:0] r;
    case (c)
      2'd0:    r = -LEVEL_HI;
      2'd1:    r = -UNIT;
      2'd2:    r = UNIT;
      default: r = LEVEL_HI;
    endcase
    return r;
  endfunction

  // (2n - 15) * 2^(FRACTION_BITS-1)
  function automatic logic signed [15:0] nibble_level(input logic [3:0] n);
    logic signed [5:0] t;
    t = $signed({1'b0, n, 1'b0}) - 6'sd15;
    return 16'(t) <<< (FRACTION_BITS - 1);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
    logic signed [15:0] r;
    if (v > SAT_MAX) begin
      r = 16'sh7fff;
    end else if (v < SAT_MIN) begin
      r = -16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  function automatic logic [2:0] last_index(input logic [1:0] depth);
    logic [2:0] r;
    case (depth)
      piqu_pkg::DEPTH_2: r = 3'd7;
      piqu_pkg::DEPTH_4: r = 3'd3;
      piqu_pkg::DEPTH_8: r = 3'd1;
      default:           r = 3'd0;
    endcase
    return r;
  endfunction

  piqu_pkg::job_t     cur;
  logic               busy;
  logic [2:0]         idx;
  logic [2:0]         last_idx;
  logic               adv;
  logic               is_last;
  logic signed [15:0] re;
  logic signed [15:0] im;

  assign adv      = busy && (!sample_valid || !sample_stall);
  assign is_last  = (idx == last_idx);
  assign job_take = job_valid && (!busy || (adv && is_last));

  always_comb begin
    logic [7:0] sel;
    logic [1:0] bits2;
    logic [3:0] nib;
    sel   = cur.odd_byte;
    bits2 = 2'd0;
    nib   = 4'd0;
    re    = 16'sd0;
    im    = 16'sd0;
    case (cur.depth)
      piqu_pkg::DEPTH_2: begin
        sel   = idx[2] ? cur.even_byte : cur.odd_byte;
        bits2 = 2'(sel >> {idx[1:0], 1'b0});
        re    = bits2[1] ? UNIT : -UNIT;
        im    = bits2[0] ? UNIT : -UNIT;
      end
      piqu_pkg::DEPTH_4: begin
        sel = idx[1] ? cur.even_byte : cur.odd_byte;
        nib = idx[0] ? sel[7:4] : sel[3:0];
        re  = level4(nib[3:2]);
        im  = level4(nib[1:0]);
      end
      piqu_pkg::DEPTH_8: begin
        sel = idx[0] ? cur.even_byte : cur.odd_byte;
        re  = nibble_level(sel[7:4]);
        im  = nibble_level(sel[3:0]);
      end
      default: begin
        re = sat16(PW'($signed(cur.odd_byte)) <<< FRACTION_BITS);
        im = sat16(PW'($signed(cur.even_byte)) <<< FRACTION_BITS);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      sample_valid <= 1'b0;
    end else begin
      if (job_take) begin
        busy <= 1'b1;
      end else if (adv && is_last) begin
        busy <= 1'b0;
      end
      if (adv) begin
        sample_valid <= 1'b1;
      end else if (!sample_stall) begin
        sample_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur      <= job;
      idx      <= 3'd0;
      last_idx <= last_index(job.depth);
    end else if (adv) begin
      idx <= idx + 3'd1;
    end
    if (adv) begin
      sample_real <= re;
      sample_imag <= im;
      last_of_run <= is_last;
    end
  end

  `PIQU_ASSERT(a_idx_range, clk, rst, busy |-> (idx <= last_idx))
  `PIQU_ASSERT(a_idx_hold, clk, rst, (busy && !adv) |=> $stable(idx))
  `PIQU_ASSERT(a_drain, clk, rst, (adv && is_last && !job_valid) |=> !busy)
  `PIQU_ASSERT(a_more_follow, clk, rst, (sample_valid && !last_of_run) |-> busy)
  `PIQU_ASSERT_ALWAYS(a_reset_clear, clk, $past(rst) |-> (!sample_valid && !busy))

endmodule

`default_nettype wire

FILE: design/packed_iq_sample_unpacker.sv
// Path: odd byte beat -> pair job register -> slicer job register -> output register.
// Throughput: one sample beat per cycle unless sample_stall holds it; a pair yields 8/4/2/1
//   samples at 2/4/8/16-bit depth, a pace set by the single sample slicer.
// Bytes are accepted every cycle while the pair job register is free or being drained.
// Reset (rst, synchronous): pair phase to even, no pending job or beat, sample_depth to 4-bit.
// ----------------------------------------------------------------------------
// packed_iq_sample_unpacker
// Unpacks raw byte pairs into complex samples in signed fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_iq_sample_unpacker #(
  parameter int FRACTION_BITS = 8   // fraction bits of the sample format, 4..12
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // byte input channel
  input  wire logic         byte_valid,
  output logic              byte_stall,
  input  wire logic [7:0]   byte_value,
  input  wire logic         end_of_block,
  // sample depth register: 0 = 2-bit, 1 = 4-bit, 2 = 8-bit, 3 = 16-bit
  input  wire logic         sample_depth_we,
  input  wire logic [1:0]   sample_depth,
  // sample output channel
  output logic              sample_valid,
  input  wire logic         sample_stall,
  output logic signed [15:0] sample_real,
  output logic signed [15:0] sample_imag,
  output logic              last_of_run
);

  // Two stages:
  //   piqu_pair   - holds the even byte; when the odd byte arrives the whole pair,
  //                 with the depth in force, is latched as one job. A lone even
  //                 byte flagged end_of_block is dropped.
  //   piqu_slicer - steps an index over the job (odd byte first, low bits first)
  //                 and writes one sample per beat into the output register. The
  //                 next job is taken in the same cycle the last sample moves out,
  //                 so jobs run back to back, but a stalled output stalls the bytes.

  piqu_pkg::job_t job;
  logic           job_valid;
  logic           job_take;

  piqu_pair u_pair (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .byte_value      (byte_value),
    .end_of_block    (end_of_block),
    .sample_depth_we (sample_depth_we),
    .sample_depth    (sample_depth),
    .job_valid       (job_valid),
    .job             (job),
    .job_take        (job_take)
  );

  piqu_slicer #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_slicer (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job          (job),
    .job_take     (job_take),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_real  (sample_real),
    .sample_imag  (sample_imag),
    .last_of_run  (last_of_run)
  );

endmodule

`default_nettype wire
